// ===== src/nss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_pkg - shared types and constants for the note sequencer
// field widths, function codes, register indexes, word layouts and helpers
// ----------------------------------------------------------------------------
package nss_pkg;

    localparam int NSS_MAX_NOTES = 64;
    localparam int NSS_IDX_W     = 6;
    localparam int NSS_NOTE_W    = 17;
    localparam int NSS_DUR_W     = 16;
    localparam int NSS_FUNC_W    = 3;
    localparam int NSS_LEN_W     = 7;
    localparam int NSS_ENTRY_W   = NSS_NOTE_W + NSS_DUR_W;

    // function codes carried on tuser
    localparam logic [NSS_FUNC_W-1:0] FN_TIMER_TICK = 3'd0;
    localparam logic [NSS_FUNC_W-1:0] FN_MS_TICK    = 3'd1;
    localparam logic [NSS_FUNC_W-1:0] FN_WRITE      = 3'd2;
    localparam logic [NSS_FUNC_W-1:0] FN_START      = 3'd3;
    localparam logic [NSS_FUNC_W-1:0] FN_STOP       = 3'd4;
    localparam logic [NSS_FUNC_W-1:0] FN_SET_NOTE   = 3'd5;

    // configuration register indexes
    localparam logic CFG_SONG_LENGTH = 1'b0;
    localparam logic CFG_LOOP_ENABLE = 1'b1;

    typedef struct packed {
        logic [NSS_FUNC_W-1:0] func;
        logic [NSS_IDX_W-1:0]  entry_index;
        logic [NSS_NOTE_W-1:0] entry_note;
        logic [NSS_DUR_W-1:0]  entry_duration;
    } nss_item_t;

    typedef struct packed {
        logic                  buzzer_level;
        logic [NSS_NOTE_W-1:0] current_note;
        logic                  tone_on;
        logic                  song_active;
        logic [NSS_IDX_W-1:0]  note_index;
    } nss_result_t;

    // table access; entry word is {duration, note}
    typedef struct packed {
        logic                   wr_en;
        logic [NSS_IDX_W-1:0]   wr_addr;
        logic [NSS_ENTRY_W-1:0] wr_data;
        logic                   rd_en;
        logic [NSS_IDX_W-1:0]   rd_addr;
    } nss_ram_req_t;

    // song length as used: zero acts as one, clamped to the table size
    function automatic logic [NSS_LEN_W-1:0] nss_eff_len(input logic [NSS_LEN_W-1:0] len);
        logic [NSS_LEN_W-1:0] r;
        r = len;
        if (len == '0) begin
            r = NSS_LEN_W'(1);
        end else if (len > NSS_LEN_W'(NSS_MAX_NOTES)) begin
            r = NSS_LEN_W'(NSS_MAX_NOTES);
        end
        return r;
    endfunction

    // entry that follows pos in the song, wrapping to zero at the end
    function automatic logic [NSS_IDX_W-1:0] nss_next_addr(input logic [NSS_IDX_W-1:0] pos,
                                                           input logic [NSS_LEN_W-1:0] len);
        logic [NSS_LEN_W-1:0] inc;
        inc = NSS_LEN_W'(pos) + NSS_LEN_W'(1);
        if (inc < len) begin
            return inc[NSS_IDX_W-1:0];
        end
        return '0;
    endfunction

endpackage

// ===== src/nss_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_ram - generic single-port-write, single-port-read ram
// one write and one registered read per cycle, contents not reset
// ----------------------------------------------------------------------------
module nss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/nss_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_seq - tone timer and song sequencer core
// updates the scalar state per word and keeps the next song entry fetched
// ----------------------------------------------------------------------------
module nss_seq (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               item_valid,
    input  nss_pkg::nss_item_t                 item,
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [nss_pkg::NSS_LEN_W-1:0]      cfg_wdata,
    output nss_pkg::nss_ram_req_t              ram_req,
    input  logic [nss_pkg::NSS_ENTRY_W-1:0]    ram_rdata,
    output nss_pkg::nss_result_t               result
);

    localparam int IW = nss_pkg::NSS_IDX_W;
    localparam int NW = nss_pkg::NSS_NOTE_W;
    localparam int DW = nss_pkg::NSS_DUR_W;
    localparam int LW = nss_pkg::NSS_LEN_W;

    // control state
    logic [LW-1:0] len_reg, len_next;
    logic          loop_reg, loop_next;
    logic [NW-1:0] playing_reg, playing_next;
    logic [NW-1:0] hpc_reg, hpc_next;
    logic [DW-1:0] elapsed_reg, elapsed_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic          seq_reg, seq_next;
    logic          pin_reg, pin_next;
    logic          pend_reg, pend_next;

    // cached table entries
    logic [DW-1:0] cur_dur_reg, cur_dur_next;
    logic [NW-1:0] e0_note_reg, e0_note_next;
    logic [DW-1:0] e0_dur_reg, e0_dur_next;
    logic [NW-1:0] nxt_note_reg, nxt_note_next;
    logic [DW-1:0] nxt_dur_reg, nxt_dur_next;
    logic [IW-1:0] nxt_addr_reg, nxt_addr_next;

    logic [LW-1:0] eff_len;
    logic [NW-1:0] nxt_note;
    logic [DW-1:0] nxt_dur;
    logic [DW:0]   elapsed_inc;
    logic [LW-1:0] pos_inc;
    logic [IW-1:0] adv_pos;
    logic          advance;

    assign eff_len     = nss_pkg::nss_eff_len(len_reg);
    assign nxt_note    = pend_reg ? ram_rdata[NW-1:0] : nxt_note_reg;
    assign nxt_dur     = pend_reg ? ram_rdata[NW +: DW] : nxt_dur_reg;
    assign elapsed_inc = (DW+1)'(elapsed_reg) + (DW+1)'(1);
    assign pos_inc     = LW'(pos_reg) + LW'(1);

    always_comb begin
        len_next      = len_reg;
        loop_next     = loop_reg;
        playing_next  = playing_reg;
        hpc_next      = hpc_reg;
        elapsed_next  = elapsed_reg;
        pos_next      = pos_reg;
        seq_next      = seq_reg;
        pin_next      = pin_reg;
        pend_next     = 1'b0;
        cur_dur_next  = cur_dur_reg;
        e0_note_next  = e0_note_reg;
        e0_dur_next   = e0_dur_reg;
        nxt_note_next = nxt_note;
        nxt_dur_next  = nxt_dur;
        nxt_addr_next = nxt_addr_reg;
        adv_pos       = '0;
        advance       = 1'b0;
        ram_req       = '0;

        if (item_valid) begin
            unique case (item.func)
                nss_pkg::FN_TIMER_TICK: begin
                    if (playing_reg != '0) begin
                        if (hpc_reg <= NW'(1)) begin
                            pin_next = ~pin_reg;
                            hpc_next = playing_reg;
                        end else begin
                            hpc_next = hpc_reg - NW'(1);
                        end
                    end
                end
                nss_pkg::FN_MS_TICK: begin
                    if (seq_reg) begin
                        if (elapsed_inc >= (DW+1)'(cur_dur_reg)) begin
                            elapsed_next = '0;
                            if (pos_inc < eff_len) begin
                                adv_pos = pos_inc[IW-1:0];
                                advance = 1'b1;
                            end else if (loop_reg) begin
                                adv_pos = '0;
                                advance = 1'b1;
                            end else begin
                                seq_next     = 1'b0;
                                pos_next     = '0;
                                playing_next = '0;
                                hpc_next     = '0;
                            end
                            if (advance) begin
                                pos_next        = adv_pos;
                                playing_next    = nxt_note;
                                hpc_next        = nxt_note;
                                cur_dur_next    = nxt_dur;
                                ram_req.rd_en   = 1'b1;
                                ram_req.rd_addr = nss_pkg::nss_next_addr(adv_pos, eff_len);
                                nxt_addr_next   = ram_req.rd_addr;
                                pend_next       = 1'b1;
                            end
                        end else begin
                            elapsed_next = elapsed_inc[DW-1:0];
                        end
                    end
                end
                nss_pkg::FN_WRITE: begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = item.entry_index;
                    ram_req.wr_data = {item.entry_duration, item.entry_note};
                    // keep the cached copies coherent with the table
                    if (item.entry_index == pos_reg) begin
                        cur_dur_next = item.entry_duration;
                    end
                    if (item.entry_index == '0) begin
                        e0_note_next = item.entry_note;
                        e0_dur_next  = item.entry_duration;
                    end
                    if (item.entry_index == nxt_addr_reg) begin
                        nxt_note_next = item.entry_note;
                        nxt_dur_next  = item.entry_duration;
                    end
                end
                nss_pkg::FN_START: begin
                    seq_next        = 1'b1;
                    elapsed_next    = '0;
                    pos_next        = '0;
                    playing_next    = e0_note_reg;
                    hpc_next        = e0_note_reg;
                    cur_dur_next    = e0_dur_reg;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = nss_pkg::nss_next_addr('0, eff_len);
                    nxt_addr_next   = ram_req.rd_addr;
                    pend_next       = 1'b1;
                end
                nss_pkg::FN_STOP: begin
                    seq_next     = 1'b0;
                    elapsed_next = '0;
                    pos_next     = '0;
                    playing_next = '0;
                    hpc_next     = '0;
                end
                nss_pkg::FN_SET_NOTE: begin
                    playing_next = item.entry_note;
                    hpc_next     = item.entry_note;
                end
                default: begin
                end
            endcase
        end

        if (cfg_wr_en) begin
            unique case (cfg_index)
                nss_pkg::CFG_SONG_LENGTH: begin
                    // length change moves the song end, so refetch the follower
                    len_next        = cfg_wdata;
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = nss_pkg::nss_next_addr(pos_reg,
                                                             nss_pkg::nss_eff_len(cfg_wdata));
                    nxt_addr_next   = ram_req.rd_addr;
                    pend_next       = 1'b1;
                end
                nss_pkg::CFG_LOOP_ENABLE: begin
                    loop_next = cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        result.buzzer_level = pin_next;
        result.current_note = playing_next;
        result.tone_on      = (playing_next != '0);
        result.song_active  = seq_next;
        result.note_index   = pos_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= LW'(1);
            loop_reg    <= 1'b0;
            playing_reg <= '0;
            hpc_reg     <= '0;
            elapsed_reg <= '0;
            pos_reg     <= '0;
            seq_reg     <= 1'b0;
            pin_reg     <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            len_reg     <= len_next;
            loop_reg    <= loop_next;
            playing_reg <= playing_next;
            hpc_reg     <= hpc_next;
            elapsed_reg <= elapsed_next;
            pos_reg     <= pos_next;
            seq_reg     <= seq_next;
            pin_reg     <= pin_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_dur_reg  <= cur_dur_next;
        e0_note_reg  <= e0_note_next;
        e0_dur_reg   <= e0_dur_next;
        nxt_note_reg <= nxt_note_next;
        nxt_dur_reg  <= nxt_dur_next;
        nxt_addr_reg <= nxt_addr_next;
    end

    a_idle_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !seq_reg |-> (pos_reg == '0))
        else $error("song position not zero while sequencer is off");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        hpc_reg <= playing_reg)
        else $error("half-period counter above playing note");

    a_start_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_valid && item.func == nss_pkg::FN_START)
            |=> (seq_reg && pos_reg == '0 && pend_reg))
        else $error("start did not restart the song with a fetch");

endmodule

// ===== src/nss_obuf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nss_obuf - two-word result buffer
// lets the core take a new word while a finished result is stalled
// ----------------------------------------------------------------------------
module nss_obuf (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  nss_pkg::nss_result_t push_data,
    output logic                 can_push,
    output logic                 out_valid,
    input  logic                 out_ready,
    output nss_pkg::nss_result_t out_data
);

    logic [1:0]           count_reg, count_next;
    nss_pkg::nss_result_t q0_reg, q0_next;
    nss_pkg::nss_result_t q1_reg, q1_next;
    logic                 pop;

    assign can_push  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = q0_reg;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        q0_next    = q0_reg;
        q1_next    = q1_reg;
        if (push && pop) begin
            if (count_reg == 2'd1) begin
                q0_next = push_data;
            end else begin
                q0_next = q1_reg;
                q1_next = push_data;
            end
        end else if (pop) begin
            q0_next    = q1_reg;
            count_next = count_reg - 2'd1;
        end else if (push) begin
            if (count_reg == 2'd0) begin
                q0_next = push_data;
            end else begin
                q1_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result buffer overflow");

endmodule

// ===== src/note_sequencer_square_tone.sv =====
`timescale 1ns / 1ps
// a result word is formed combinationally from the updated state and registered in the result buffer
// throughput: one word per cycle, sustained, while the result side keeps up
// a two-word result buffer keeps the input open while one result is stalled
// reset (aresetn low, synchronous): pin, note, counters, position and sequencer
// clear, song length becomes one and looping off; note table is not cleared
// and an entry reads as undefined until it has been written
// ----------------------------------------------------------------------------
// note_sequencer_square_tone - square-wave buzzer tone with song sequencer
// note table in ram, tone and song state in registers; while the result side keeps up, one word per cycle
// ----------------------------------------------------------------------------
module note_sequencer_square_tone (
    input  logic        aclk,
    input  logic        aresetn,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_index[5:0], entry_note[22:6],
                                   // entry_duration[38:23], zero pad[39]
    input  logic [2:0]  s_tuser,   // func[2:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // buzzer_level[0], current_note[17:1],
                                   // tone_on[18], song_active[19],
                                   // note_index[25:20], zero pad[31:26]
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_index,  // 0 song_length, 1 loop_enable
    input  logic [6:0]  cfg_wdata
);

    nss_pkg::nss_item_t    item;
    nss_pkg::nss_result_t  core_result;
    nss_pkg::nss_result_t  out_result;
    nss_pkg::nss_ram_req_t ram_req;
    logic [nss_pkg::NSS_ENTRY_W-1:0] ram_rdata;
    logic                  item_valid;

    // unpack the input word
    always_comb begin
        item.func           = s_tuser;
        item.entry_index    = s_tdata[5:0];
        item.entry_note     = s_tdata[22:6];
        item.entry_duration = s_tdata[38:23];
    end

    assign item_valid = s_tvalid && s_tready;

    // note table: one write port for table writes, one read port that
    // prefetches the song entry that will follow the current one
    nss_ram #(
        .WIDTH (nss_pkg::NSS_ENTRY_W),
        .DEPTH (nss_pkg::NSS_MAX_NOTES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_req.wr_en),
        .wr_addr (ram_req.wr_addr),
        .wr_data (ram_req.wr_data),
        .rd_en   (ram_req.rd_en),
        .rd_addr (ram_req.rd_addr),
        .rd_data (ram_rdata)
    );

    // state update: timer tick, ms tick, table write, start, stop, set note
    nss_seq u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata),
        .result     (core_result)
    );

    // result buffer decouples the result side from the input side
    nss_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (item_valid),
        .push_data (core_result),
        .can_push  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    // pack the result word
    assign m_tdata = {6'd0,
                      out_result.note_index,
                      out_result.song_active,
                      out_result.tone_on,
                      out_result.current_note,
                      out_result.buzzer_level};

endmodule
